// ===== rtl/htlm_pkg.sv =====
// ----------------------------------------------------------------------------
// htlm_pkg
// Shared types and codes for the lockable tree block.
// ----------------------------------------------------------------------------
package htlm_pkg;

  localparam int NODES_DEF = 64;
  localparam int ID_W      = 6;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_SET_PARENT = 2'd0,
    REQ_LOCK       = 2'd1,
    REQ_UNLOCK     = 2'd2,
    REQ_QUERY      = 2'd3
  } req_e;

  // result word handed from the sequencer to the output register
  typedef struct packed {
    logic took;
    logic locked;
  } res_t;

endpackage

// ===== rtl/htlm_node_ram.sv =====
// ----------------------------------------------------------------------------
// htlm_node_ram
// Node table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module htlm_node_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/htlm_ctrl.sv =====
// ----------------------------------------------------------------------------
// htlm_ctrl
// Request sequencer: reads the addressed node, walks the ancestor chain one
// table read per hop, and does read-modify-write updates of the counts.
// ----------------------------------------------------------------------------
module htlm_ctrl #(
  parameter int  NODES = htlm_pkg::NODES_DEF,
  localparam int NW    = $clog2(NODES),
  localparam int CW    = $clog2(NODES * NODES + 1),
  localparam int EW    = NW + CW + 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [htlm_pkg::ID_W-1:0] node_id_i,
  input  logic [htlm_pkg::ID_W-1:0] parent_id_i,
  input  logic                      has_parent_i,
  output logic                      res_valid_o,
  output htlm_pkg::res_t            res_o,
  input  logic                      res_ready_i,
  output logic                      mem_we_o,
  output logic [NW-1:0]             mem_waddr_o,
  output logic [EW-1:0]             mem_wdata_o,
  output logic [NW-1:0]             mem_raddr_o,
  input  logic [EW-1:0]             mem_rdata_i
);

  localparam int HW = $clog2(NODES + 1);
  localparam int TW = $clog2(NODES + 1);

  typedef struct packed {
    logic          valid;
    logic [NW-1:0] link;
    logic          lock;
    logic [CW-1:0] cnt;
  } ent_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NODE_RD,
    ST_NODE_CHK,
    ST_CHK_RD,
    ST_CHK_EVAL,
    ST_LOCK_SET,
    ST_ADJ_RD,
    ST_ADJ_UPD,
    ST_DONE
  } state_e;

  state_e           state_q, state_d;
  htlm_pkg::req_e   req_q, req_d;
  logic [NW-1:0]    node_q, node_d;
  logic [NW-1:0]    par_q, par_d;
  logic             hasp_q, hasp_d;
  logic             par_ok_q, par_ok_d;
  ent_t             ent_q, ent_d;
  logic [NW-1:0]    cur_q, cur_d;
  logic [HW-1:0]    hop_q, hop_d;
  logic [TW-1:0]    total_q, total_d;
  logic [NW-1:0]    clr_q, clr_d;
  htlm_pkg::res_t   res_q, res_d;

  always_comb begin
    ent_t rd;
    ent_t wr;
    rd          = ent_t'(mem_rdata_i);
    wr          = rd;
    state_d     = state_q;
    req_d       = req_q;
    node_d      = node_q;
    par_d       = par_q;
    hasp_d      = hasp_q;
    par_ok_d    = par_ok_q;
    ent_d       = ent_q;
    cur_d       = cur_q;
    hop_d       = hop_q;
    total_d     = total_q;
    clr_d       = clr_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_raddr_o = cur_q;
    res_valid_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // zero every entry: roots, unlocked, counts at zero
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        wr          = '0;
        clr_d       = clr_q + NW'(1);
        if (clr_q == NW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = htlm_pkg::req_e'(req_type_i);
          node_d   = NW'(node_id_i);
          par_d    = NW'(parent_id_i);
          hasp_d   = has_parent_i;
          par_ok_d = 32'(parent_id_i) < NODES;
          if (32'(node_id_i) < NODES) begin
            state_d = ST_NODE_RD;
          end else begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        end
      end

      ST_NODE_RD: begin
        mem_raddr_o = node_q;
        state_d     = ST_NODE_CHK;
      end

      ST_NODE_CHK: begin
        ent_d        = rd;
        cur_d        = rd.link;
        hop_d        = HW'(1);
        res_d.took   = 1'b0;
        res_d.locked = rd.lock;
        state_d      = ST_DONE;
        case (req_q)
          htlm_pkg::REQ_SET_PARENT: begin
            if (total_q == '0 && (!hasp_q || par_ok_q)) begin
              wr.valid    = hasp_q;
              if (hasp_q) begin
                wr.link = par_q;
              end
              mem_we_o    = 1'b1;
              mem_waddr_o = node_q;
              res_d.took  = 1'b1;
            end
          end
          htlm_pkg::REQ_LOCK: begin
            if (!rd.lock && rd.cnt == '0) begin
              state_d = rd.valid ? ST_CHK_RD : ST_LOCK_SET;
            end
          end
          htlm_pkg::REQ_UNLOCK: begin
            if (rd.lock) begin
              wr.lock      = 1'b0;
              mem_we_o     = 1'b1;
              mem_waddr_o  = node_q;
              total_d      = (total_q != '0) ? total_q - TW'(1) : total_q;
              res_d.took   = 1'b1;
              res_d.locked = 1'b0;
              state_d      = rd.valid ? ST_ADJ_RD : ST_DONE;
            end
          end
          default: begin
          end
        endcase
      end

      ST_CHK_RD: begin
        state_d = ST_CHK_EVAL;
      end

      ST_CHK_EVAL: begin
        if (rd.lock) begin
          // locked ancestor: refused, node stays unlocked
          state_d = ST_DONE;
        end else if (rd.valid && hop_q != HW'(NODES)) begin
          cur_d   = rd.link;
          hop_d   = hop_q + HW'(1);
          state_d = ST_CHK_RD;
        end else begin
          state_d = ST_LOCK_SET;
        end
      end

      ST_LOCK_SET: begin
        wr           = ent_q;
        wr.lock      = 1'b1;
        mem_we_o     = 1'b1;
        mem_waddr_o  = node_q;
        total_d      = total_q + TW'(1);
        res_d.took   = 1'b1;
        res_d.locked = 1'b1;
        cur_d        = ent_q.link;
        hop_d        = HW'(1);
        state_d      = ent_q.valid ? ST_ADJ_RD : ST_DONE;
      end

      ST_ADJ_RD: begin
        state_d = ST_ADJ_UPD;
      end

      ST_ADJ_UPD: begin
        if (req_q == htlm_pkg::REQ_LOCK) begin
          wr.cnt = rd.cnt + CW'(1);
        end else if (rd.cnt != '0) begin
          wr.cnt = rd.cnt - CW'(1);
        end
        mem_we_o = 1'b1;
        if (rd.valid && hop_q != HW'(NODES)) begin
          cur_d   = rd.link;
          hop_d   = hop_q + HW'(1);
          state_d = ST_ADJ_RD;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    mem_wdata_o = wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      total_q  <= '0;
      req_q    <= htlm_pkg::REQ_QUERY;
      node_q   <= '0;
      par_q    <= '0;
      hasp_q   <= 1'b0;
      par_ok_q <= 1'b0;
      ent_q    <= '0;
      cur_q    <= '0;
      hop_q    <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      total_q  <= total_d;
      req_q    <= req_d;
      node_q   <= node_d;
      par_q    <= par_d;
      hasp_q   <= hasp_d;
      par_ok_q <= par_ok_d;
      ent_q    <= ent_d;
      cur_q    <= cur_d;
      hop_q    <= hop_d;
      res_q    <= res_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign res_o      = res_q;

endmodule

// ===== rtl/hierarchical_tree_lock_manager.sv =====
// ----------------------------------------------------------------------------
// hierarchical_tree_lock_manager
// Lockable tree of NODES nodes with per-node counts of locked descendants.
// ----------------------------------------------------------------------------
// After reset the block sweeps its node table, one entry per cycle, and
// holds in_stall_o high until the sweep is done. Each request then runs
// on the table's read and write ports under a small sequencer. Query, set
// parent, unlock of an unlocked node and a lock refused at the node itself
// read the node and finish; a node index at or above NODES is answered
// without a table read. Unlock writes the node, then does one read and one
// write per ancestor for the count update. A granted lock does one table
// read per hop for the ancestor check, writes the lock bit, then does one
// read and one write per hop for the count update; the ancestor walks are
// capped at NODES hops. A lock refused by a locked ancestor stops there.
// A finished result waits in the sequencer while the output register holds
// a stalled word. Once the result is loaded the sequencer is idle again and
// can take the next word, while that result may still wait on the output
// register.
// Counts are kept wide enough for a parent table with cycles, where one
// lock can bump a node's count once per trip round the loop.
// ----------------------------------------------------------------------------
module hierarchical_tree_lock_manager #(
  parameter int NODES = htlm_pkg::NODES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [htlm_pkg::ID_W-1:0] node_id_i,
  input  logic [htlm_pkg::ID_W-1:0] parent_id_i,
  input  logic                      has_parent_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      took_effect_o,
  output logic                      node_locked_o
);

  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES * NODES + 1);
  localparam int EW = NW + CW + 2;

  logic           mem_we;
  logic [NW-1:0]  mem_waddr;
  logic [EW-1:0]  mem_wdata;
  logic [NW-1:0]  mem_raddr;
  logic [EW-1:0]  mem_rdata;

  logic           res_valid;
  logic           res_ready;
  htlm_pkg::res_t res;

  logic           out_valid_q;
  htlm_pkg::res_t out_q;

  // entry: parent valid, parent link, lock bit, locked-descendant count
  htlm_node_ram #(
    .DEPTH (NODES),
    .AW    (NW),
    .DW    (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  htlm_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .node_id_i    (node_id_i),
    .parent_id_i  (parent_id_i),
    .has_parent_i (has_parent_i),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign took_effect_o = out_q.took;
  assign node_locked_o = out_q.locked;

endmodule

// ===== rtl/htlm_chk.sv =====
// ----------------------------------------------------------------------------
// htlm_chk
// Port-level checks for the lockable tree block, bound to the top level.
// ----------------------------------------------------------------------------
module htlm_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic took_effect_o,
  input logic node_locked_o
);

  // table sweep keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input open during table sweep");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word taken while busy");

  // no result can appear the cycle after a word is taken
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(took_effect_o) && $stable(node_locked_o)))
    else $error("stalled result changed");

endmodule

bind hierarchical_tree_lock_manager htlm_chk u_htlm_chk (.*);
